// ===== design/fbpa_pkg.sv =====
// Package for the fixed block pool allocator: operation and status codes,
// register indexes, configuration struct and width helpers.
// No dependencies.
package fbpa_pkg;

   localparam int POOL_BLOCKS_DEFAULT     = 1024;
   localparam int MIN_BLOCK_BYTES_DEFAULT = 8;
   localparam int MAX_BLOCK_BYTES         = 4096;

   localparam int BYTES_W     = 13;
   localparam int CFG_COUNT_W = 11;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int GRANTS_W    = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_FREE_ALL = 2'd2,
      OP_RESTART  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_NO_BLOCK    = 2'd1,
      ST_NONE_IN_USE = 2'd2,
      ST_BAD_INDEX   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_BYTES    = 2'd0,
      CSR_INITIAL_BLOCKS = 2'd1,
      CSR_GROW_BLOCKS    = 2'd2,
      CSR_GROW_DOUBLING  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTES_W-1:0]     block_bytes;
      logic [CFG_COUNT_W-1:0] initial_blocks;
      logic [CFG_COUNT_W-1:0] grow_blocks;
      logic                   grow_doubling;
   } cfg_type;

   // bits of a block index
   function automatic int index_width(input int pool);
      return $clog2(pool);
   endfunction

   // bits of a count that can reach the pool size
   function automatic int count_width(input int pool);
      return $clog2(pool + 1);
   endfunction

   // bits of a byte offset into the pool
   function automatic int offset_width(input int pool);
      return $clog2(pool) + $clog2(MAX_BLOCK_BYTES);
   endfunction

   // round a field width up to whole bytes
   function automatic int byte_round(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

   // packed width of the response fields carried in tdata
   function automatic int rsp_fields_width(input int pool);
      return index_width(pool) + offset_width(pool) + 2 * count_width(pool) + GRANTS_W;
   endfunction

endpackage

// ===== design/fixed_block_pool_allocator.sv =====
// Allocate, free and restart: the request is taken in idle, executed, and its response
// registered; no request is taken meanwhile (stack read, then update and write back).
// Free-all: reads each provision back, then pushes its blocks, one stack write a cycle.
// A held response stalls the engine until it is taken.
// Reset is synchronous, active high; it clears counters and control state at once,
// the memories keep their contents and need no clearing pass.
module fixed_block_pool_allocator #(
   parameter int  POOL_BLOCKS     = fbpa_pkg::POOL_BLOCKS_DEFAULT,
   parameter int  MIN_BLOCK_BYTES = fbpa_pkg::MIN_BLOCK_BYTES_DEFAULT,
   localparam int REQ_DATA_W = fbpa_pkg::byte_round(fbpa_pkg::index_width(POOL_BLOCKS)),
   localparam int RSP_DATA_W = fbpa_pkg::byte_round(fbpa_pkg::rsp_fields_width(POOL_BLOCKS))
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_DATA_W-1:0]            req_tdata,  // block_index
   input  logic [fbpa_pkg::OP_W-1:0]        req_tuser,  // operation
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_DATA_W-1:0]            rsp_tdata,  // granted_index, byte_offset,
                                                        // blocks_in_use, blocks_provisioned,
                                                        // total_grants
   output logic [fbpa_pkg::STATUS_W-1:0]    rsp_tuser,  // status
   // configuration write port
   input  logic                             csr_we,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fbpa_pkg::*;

   localparam int IDX_W = index_width(POOL_BLOCKS);
   localparam int CNT_W = count_width(POOL_BLOCKS);
   localparam int OFS_W = offset_width(POOL_BLOCKS);

   cfg_type                 cfg_ff, cfg_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   logic [STATUS_W-1:0]     rsp_tuser_ff;

   logic                    res_room, res_valid;
   status_type              res_status;
   logic [IDX_W-1:0]        res_granted;
   logic [OFS_W-1:0]        res_offset;
   logic [CNT_W-1:0]        res_in_use, res_provisioned;
   logic [GRANTS_W-1:0]     res_grants;

   // decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_BYTES:    cfg_in.block_bytes    = csr_wdata[BYTES_W-1:0];
            CSR_INITIAL_BLOCKS: cfg_in.initial_blocks = csr_wdata[CFG_COUNT_W-1:0];
            CSR_GROW_BLOCKS:    cfg_in.grow_blocks    = csr_wdata[CFG_COUNT_W-1:0];
            CSR_GROW_DOUBLING:  cfg_in.grow_doubling  = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_bytes    <= BYTES_W'(8);
         cfg_ff.initial_blocks <= '0;
         cfg_ff.grow_blocks    <= '0;
         cfg_ff.grow_doubling  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbpa_core #(
      .POOL_BLOCKS     (POOL_BLOCKS),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (req_tvalid),
      .cmd_ready       (req_tready),
      .cmd_op          (op_type'(req_tuser)),
      .cmd_index       (req_tdata[IDX_W-1:0]),
      .res_room        (res_room),
      .res_valid       (res_valid),
      .res_status      (res_status),
      .res_granted     (res_granted),
      .res_offset      (res_offset),
      .res_in_use      (res_in_use),
      .res_provisioned (res_provisioned),
      .res_grants      (res_grants)
   );

   // response register: load when empty or being drained
   assign res_room = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (res_valid) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // pack the response fields, lowest first
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_tdata_ff <= RSP_DATA_W'({res_grants, res_provisioned, res_in_use,
                                      res_offset, res_granted});
         rsp_tuser_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== design/fbpa_core.sv =====
// Allocator engine: free stack memory, provision table memory and the
// sequencer for allocate, free, free-all and restart.
// Depends on fbpa_pkg.
module fbpa_core #(
   parameter int  POOL_BLOCKS     = fbpa_pkg::POOL_BLOCKS_DEFAULT,
   parameter int  MIN_BLOCK_BYTES = fbpa_pkg::MIN_BLOCK_BYTES_DEFAULT,
   localparam int IDX_W           = fbpa_pkg::index_width(POOL_BLOCKS),
   localparam int CNT_W           = fbpa_pkg::count_width(POOL_BLOCKS),
   localparam int OFS_W           = fbpa_pkg::offset_width(POOL_BLOCKS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fbpa_pkg::cfg_type            cfg,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  fbpa_pkg::op_type             cmd_op,
   input  logic [IDX_W-1:0]             cmd_index,
   input  logic                         res_room,
   output logic                         res_valid,
   output fbpa_pkg::status_type         res_status,
   output logic [IDX_W-1:0]             res_granted,
   output logic [OFS_W-1:0]             res_offset,
   output logic [CNT_W-1:0]             res_in_use,
   output logic [CNT_W-1:0]             res_provisioned,
   output logic [fbpa_pkg::GRANTS_W-1:0] res_grants
);
   import fbpa_pkg::*;

   localparam int PROD_W = IDX_W + BYTES_W;
   localparam logic [CNT_W-1:0]   POOL_C  = CNT_W'(POOL_BLOCKS);
   localparam logic [CNT_W:0]     POOL_X  = (CNT_W + 1)'(POOL_BLOCKS);
   localparam logic [BYTES_W-1:0] MIN_B   = BYTES_W'(MIN_BLOCK_BYTES);
   localparam logic [BYTES_W-1:0] MAX_B   = BYTES_W'(MAX_BLOCK_BYTES);
   localparam logic [BYTES_W-1:0] RESET_B = (MIN_B > BYTES_W'(8)) ? MIN_B : BYTES_W'(8);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FA_LOAD,
      S_FA_PUSH,
      S_FA_DONE
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [IDX_W-1:0]     index_ff, index_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]     fresh_low_ff, fresh_low_in;
   logic [CNT_W-1:0]     fresh_high_ff, fresh_high_in;
   logic [CNT_W-1:0]     prov_count_ff, prov_count_in;
   logic [CNT_W-1:0]     prov_num_ff, prov_num_in;
   logic [CNT_W-1:0]     next_grow_ff, next_grow_in;
   logic [CNT_W-1:0]     in_use_ff, in_use_in;
   logic [GRANTS_W-1:0]  grants_ff, grants_in;
   logic [BYTES_W-1:0]   latched_bytes_ff, latched_bytes_in;
   logic                 doubling_ff, doubling_in;

   // free-all sweep registers
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [CNT_W-1:0]     end_ff, end_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     b_ff, b_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;

   // free stack memory
   logic [IDX_W-1:0]     stack_mem [POOL_BLOCKS];
   logic                 stack_we, stack_re;
   logic [IDX_W-1:0]     stack_waddr, stack_raddr, stack_wdata;
   logic [IDX_W-1:0]     stack_rdata_ff;

   // provision table: first block of each provision, filled up to prov_num_ff
   logic [IDX_W-1:0]     prov_mem [POOL_BLOCKS];
   logic                 prov_we, prov_re;
   logic [IDX_W-1:0]     prov_waddr, prov_raddr, prov_wdata;
   logic [IDX_W-1:0]     prov_rdata_ff;

   logic [CNT_W-1:0]     depth_m1, fresh_high_m1, room, grow_n, grow_top, grow_top_m1;
   logic [CNT_W:0]       grow_x2;
   logic [CNT_W-1:0]     next_dbl, alloc_index, init_cl, grow_cl, restart_grow;
   logic [CNT_W-1:0]     prov_num_m1;
   logic [IDX_W-1:0]     k_m1;
   logic [BYTES_W-1:0]   eff_bytes;
   logic [PROD_W-1:0]    alloc_product;
   logic                 stack_empty, fresh_empty, need_grow, alloc_fail, push_last;

   // allocation datapath
   assign depth_m1      = depth_ff - 1'b1;
   assign fresh_high_m1 = fresh_high_ff - 1'b1;
   assign stack_empty   = (depth_ff == '0);
   assign fresh_empty   = (fresh_high_ff <= fresh_low_ff);
   assign need_grow     = stack_empty && fresh_empty;
   assign room          = POOL_C - prov_count_ff;
   assign grow_n        = (next_grow_ff > room) ? room : next_grow_ff;
   assign grow_top      = prov_count_ff + grow_n;
   assign grow_top_m1   = grow_top - 1'b1;
   assign alloc_fail    = need_grow && (grow_n == '0);
   assign grow_x2       = {next_grow_ff, 1'b0};
   assign next_dbl      = (grow_x2 > POOL_X) ? POOL_C : grow_x2[CNT_W-1:0];
   assign alloc_index   = need_grow    ? grow_top_m1 :
                          !stack_empty ? CNT_W'(stack_rdata_ff) : fresh_high_m1;
   assign alloc_product = alloc_index[IDX_W-1:0] * latched_bytes_ff;

   // restart datapath
   assign init_cl   = (int'(cfg.initial_blocks) > POOL_BLOCKS) ? POOL_C
                                                               : CNT_W'(cfg.initial_blocks);
   assign grow_cl   = (int'(cfg.grow_blocks) > POOL_BLOCKS) ? POOL_C
                                                            : CNT_W'(cfg.grow_blocks);
   assign restart_grow = !cfg.grow_doubling ? grow_cl :
                         (init_cl == '0)    ? CNT_W'(1) : init_cl;
   assign eff_bytes = (cfg.block_bytes < MIN_B) ? MIN_B :
                      (cfg.block_bytes > MAX_B) ? MAX_B : cfg.block_bytes;

   // sweep helpers
   assign prov_num_m1 = prov_num_ff - 1'b1;
   assign k_m1        = k_ff - 1'b1;
   assign push_last   = ((CNT_W'(b_ff) + 1'b1) == end_ff);

   assign cmd_ready       = (state_ff == S_IDLE);
   assign res_in_use      = in_use_in;
   assign res_provisioned = prov_count_in;
   assign res_grants      = grants_in;

   // sequence the operations
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      index_in         = index_ff;
      depth_in         = depth_ff;
      fresh_low_in     = fresh_low_ff;
      fresh_high_in    = fresh_high_ff;
      prov_count_in    = prov_count_ff;
      prov_num_in      = prov_num_ff;
      next_grow_in     = next_grow_ff;
      in_use_in        = in_use_ff;
      grants_in        = grants_ff;
      latched_bytes_in = latched_bytes_ff;
      doubling_in      = doubling_ff;
      k_in             = k_ff;
      end_in           = end_ff;
      lo_in            = lo_ff;
      b_in             = b_ff;
      pos_in           = pos_ff;

      stack_re    = 1'b0;
      stack_raddr = depth_m1[IDX_W-1:0];
      stack_we    = 1'b0;
      stack_waddr = depth_ff[IDX_W-1:0];
      stack_wdata = index_ff;
      prov_re     = 1'b0;
      prov_raddr  = prov_num_m1[IDX_W-1:0];
      prov_we     = 1'b0;
      prov_waddr  = prov_num_ff[IDX_W-1:0];
      prov_wdata  = prov_count_ff[IDX_W-1:0];

      res_valid   = 1'b0;
      res_status  = ST_OK;
      res_granted = '0;
      res_offset  = '0;

      unique case (state_ff)
         S_IDLE: begin
            // take a transaction; fetch the stack top for an allocation
            if (cmd_valid) begin
               op_in    = cmd_op;
               index_in = cmd_index;
               state_in = S_EXEC;
               if ((cmd_op == OP_ALLOC) && !stack_empty) begin
                  stack_re = 1'b1;
               end
            end
         end

         S_EXEC: begin
            // commit only when the response register can take the result
            if (res_room) begin
               unique case (op_ff)
                  OP_ALLOC: begin
                     res_valid = 1'b1;
                     state_in  = S_IDLE;
                     if (alloc_fail) begin
                        res_status = ST_NO_BLOCK;
                     end else begin
                        res_granted = alloc_index[IDX_W-1:0];
                        res_offset  = alloc_product[OFS_W-1:0];
                        in_use_in   = in_use_ff + 1'b1;
                        grants_in   = grants_ff + 1'b1;
                        if (need_grow) begin
                           prov_we       = 1'b1;
                           prov_num_in   = prov_num_ff + 1'b1;
                           fresh_low_in  = prov_count_ff;
                           fresh_high_in = grow_top_m1;
                           prov_count_in = grow_top;
                           if (doubling_ff) begin
                              next_grow_in = next_dbl;
                           end
                        end else if (!stack_empty) begin
                           depth_in = depth_m1;
                        end else begin
                           fresh_high_in = fresh_high_m1;
                        end
                     end
                  end

                  OP_FREE: begin
                     res_valid = 1'b1;
                     state_in  = S_IDLE;
                     if (in_use_ff == '0) begin
                        res_status = ST_NONE_IN_USE;
                     end else if (CNT_W'(index_ff) >= prov_count_ff) begin
                        res_status = ST_BAD_INDEX;
                     end else if (depth_ff < POOL_C) begin
                        stack_we  = 1'b1;
                        depth_in  = depth_ff + 1'b1;
                        in_use_in = in_use_ff - 1'b1;
                     end
                  end

                  OP_FREE_ALL: begin
                     depth_in      = prov_count_ff;
                     fresh_low_in  = '0;
                     fresh_high_in = '0;
                     in_use_in     = '0;
                     if (prov_num_ff == '0) begin
                        res_valid = 1'b1;
                        state_in  = S_IDLE;
                     end else begin
                        // start with the newest provision
                        prov_re  = 1'b1;
                        k_in     = prov_num_m1[IDX_W-1:0];
                        end_in   = prov_count_ff;
                        pos_in   = '0;
                        state_in = S_FA_LOAD;
                     end
                  end

                  OP_RESTART: begin
                     res_valid        = 1'b1;
                     state_in         = S_IDLE;
                     depth_in         = '0;
                     in_use_in        = '0;
                     grants_in        = '0;
                     latched_bytes_in = eff_bytes;
                     doubling_in      = cfg.grow_doubling;
                     next_grow_in     = restart_grow;
                     fresh_low_in     = '0;
                     fresh_high_in    = init_cl;
                     prov_count_in    = init_cl;
                     prov_num_in      = '0;
                     if (init_cl != '0) begin
                        prov_we     = 1'b1;
                        prov_waddr  = '0;
                        prov_wdata  = '0;
                        prov_num_in = CNT_W'(1);
                     end
                  end

                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_FA_LOAD: begin
            // first block of the provision under rebuild
            lo_in    = prov_rdata_ff;
            b_in     = prov_rdata_ff;
            state_in = S_FA_PUSH;
         end

         S_FA_PUSH: begin
            // push the provision in ascending order
            stack_we    = 1'b1;
            stack_waddr = pos_ff;
            stack_wdata = b_ff;
            pos_in      = pos_ff + 1'b1;
            b_in        = b_ff + 1'b1;
            if (push_last) begin
               end_in = CNT_W'(lo_ff);
               if (k_ff == '0) begin
                  state_in = S_FA_DONE;
               end else begin
                  k_in       = k_m1;
                  prov_re    = 1'b1;
                  prov_raddr = k_m1;
                  state_in   = S_FA_LOAD;
               end
            end
         end

         S_FA_DONE: begin
            if (res_room) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and counters
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      index_ff <= index_in;
      k_ff     <= k_in;
      end_ff   <= end_in;
      lo_ff    <= lo_in;
      b_ff     <= b_in;
      pos_ff   <= pos_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         depth_ff         <= '0;
         fresh_low_ff     <= '0;
         fresh_high_ff    <= '0;
         prov_count_ff    <= '0;
         prov_num_ff      <= '0;
         next_grow_ff     <= '0;
         in_use_ff        <= '0;
         grants_ff        <= '0;
         latched_bytes_ff <= RESET_B;
         doubling_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         depth_ff         <= depth_in;
         fresh_low_ff     <= fresh_low_in;
         fresh_high_ff    <= fresh_high_in;
         prov_count_ff    <= prov_count_in;
         prov_num_ff      <= prov_num_in;
         next_grow_ff     <= next_grow_in;
         in_use_ff        <= in_use_in;
         grants_ff        <= grants_in;
         latched_bytes_ff <= latched_bytes_in;
         doubling_ff      <= doubling_in;
      end
   end

   // free stack memory, registered read
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rdata_ff <= stack_mem[stack_raddr];
      end
   end

   // provision table memory, registered read
   always_ff @(posedge clock) begin
      if (prov_we) begin
         prov_mem[prov_waddr] <= prov_wdata;
      end
      if (prov_re) begin
         prov_rdata_ff <= prov_mem[prov_raddr];
      end
   end

endmodule

// ===== design/fbpa_checker.sv =====
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module fbpa_checker #(
   parameter int  POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEFAULT,
   localparam int RSP_DATA_W  = fbpa_pkg::byte_round(fbpa_pkg::rsp_fields_width(POOL_BLOCKS))
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [RSP_DATA_W-1:0]         rsp_tdata,
   input logic [fbpa_pkg::STATUS_W-1:0] rsp_tuser
);
   import fbpa_pkg::*;

   localparam int IDX_W  = index_width(POOL_BLOCKS);
   localparam int CNT_W  = count_width(POOL_BLOCKS);
   localparam int OFS_W  = offset_width(POOL_BLOCKS);
   localparam int USE_LO = IDX_W + OFS_W;
   localparam int PRV_LO = USE_LO + CNT_W;

   logic [IDX_W-1:0] granted;
   logic [OFS_W-1:0] offset;
   logic [CNT_W-1:0] in_use, provisioned;

   assign granted     = rsp_tdata[IDX_W-1:0];
   assign offset      = rsp_tdata[USE_LO-1:IDX_W];
   assign in_use      = rsp_tdata[PRV_LO-1:USE_LO];
   assign provisioned = rsp_tdata[PRV_LO+CNT_W-1:PRV_LO];

   // no response is pending after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // only a successful allocation carries a block
   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (granted == '0) && (offset == '0))
      else $error("failed operation reports a block");

   // blocks in use never exceed the provisioned blocks
   a_use_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (in_use <= provisioned))
      else $error("blocks in use above provisioned count");

   // one request in flight: no request is taken in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
   .POOL_BLOCKS (POOL_BLOCKS)
) u_fbpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
